// File: hw/rtl/drkg_pkg.sv
package drkg_pkg;

    localparam int unsigned ROUND_COUNT = 16;
    localparam int unsigned HALF_BITS   = 28;
    localparam int unsigned CD_BITS     = 56;
    localparam int unsigned KEY_W       = 64;
    localparam int unsigned SUBKEY_BITS = 48;
    localparam int unsigned ROUND_W     = 4;

    typedef logic [HALF_BITS-1:0]   half_t;
    typedef logic [KEY_W-1:0]       key_t;
    typedef logic [SUBKEY_BITS-1:0] subkey_t;
    typedef logic [ROUND_W-1:0]     round_t;

    typedef struct packed {
        half_t c;
        half_t d;
    } cd_t;

    // what one cell hands to the next
    typedef struct packed {
        logic valid;
        cd_t  cd;
    } link_t;

    typedef logic [7:0] tab_entry_t;

    // standard numbering: position 1 is the MSB
    localparam tab_entry_t PC1_TAB [CD_BITS] = '{
        8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,  8'd58, 8'd50,
        8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35,
        8'd27, 8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36, 8'd63, 8'd55,
        8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7,  8'd62, 8'd54, 8'd46, 8'd38,
        8'd30, 8'd22, 8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29, 8'd21,
        8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
    };

    localparam tab_entry_t PC2_TAB [SUBKEY_BITS] = '{
        8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,  8'd3,  8'd28, 8'd15, 8'd6,
        8'd21, 8'd10, 8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,  8'd16, 8'd7,
        8'd27, 8'd20, 8'd13, 8'd2,  8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55,
        8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48, 8'd44, 8'd49, 8'd39, 8'd56,
        8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
    };

    // left rotation per round
    localparam tab_entry_t ROT_TAB [ROUND_COUNT] = '{
        8'd1, 8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
        8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd1
    };

    function automatic cd_t pc1(input key_t key);
        logic [CD_BITS-1:0] acc;
        acc = '0;
        for (int k = 0; k < CD_BITS; k++)
        begin
            acc[6'(CD_BITS - 1 - k)] = key[6'(KEY_W - PC1_TAB[k])];
        end
        return cd_t'(acc);
    endfunction

    function automatic subkey_t pc2(input cd_t cd);
        logic [CD_BITS-1:0] src;
        subkey_t            acc;
        src = cd;
        acc = '0;
        for (int k = 0; k < SUBKEY_BITS; k++)
        begin
            acc[6'(SUBKEY_BITS - 1 - k)] = src[6'(CD_BITS - PC2_TAB[k])];
        end
        return acc;
    endfunction

endpackage

// File: hw/rtl/drkg_cell.sv
module drkg_cell #(
    parameter int unsigned ROT = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  drkg_pkg::link_t link_in,
    output drkg_pkg::link_t link_out
);
    import drkg_pkg::*;

    logic valid_reg;
    cd_t  cd_reg;
    cd_t  cd_next;

    // ROT is 1 or 2
    always_comb
    begin
        if (ROT == 1)
        begin
            cd_next.c = {link_in.cd.c[HALF_BITS-2:0], link_in.cd.c[HALF_BITS-1]};
            cd_next.d = {link_in.cd.d[HALF_BITS-2:0], link_in.cd.d[HALF_BITS-1]};
        end
        else
        begin
            cd_next.c = {link_in.cd.c[HALF_BITS-3:0], link_in.cd.c[HALF_BITS-1 -: 2]};
            cd_next.d = {link_in.cd.d[HALF_BITS-3:0], link_in.cd.d[HALF_BITS-1 -: 2]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= link_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_in.valid)
        begin
            cd_reg <= cd_next;
        end
    end

    assign link_out.valid = valid_reg;
    assign link_out.cd    = cd_reg;

endmodule

// File: hw/rtl/des_round_key_generator_unit.sv
// DES key schedule: a new 64-bit key once busy drops, 16 round keys out per key.
// Round key r passes through rotation cells 0 to r, then the output register.
// Throughput: one round key per cycle; busy stays high after an accepted start until
// the key reaches the last of the 16 rotation cells feeding the single output register.
// Reset (rst_n low, async): chain emptied, busy and round_valid low.
// The receiver cannot stall; each round key is held for exactly one cycle.
module des_round_key_generator_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  drkg_pkg::key_t            cipher_key,
    output logic                      round_valid,
    output drkg_pkg::subkey_t         subkey,
    output drkg_pkg::round_t          round_number,
    output logic                      last_round
);
    import drkg_pkg::*;

    // Chain of 16 cells, one per round. Cell r holds C:D after round r's
    // rotation; a key walks one cell per cycle. A new key enters only once busy
    // drops, so at most one cell is valid in any cycle and its word goes to PC-2.
    link_t  links [ROUND_COUNT+1];

    logic   accept;
    round_t cnt_reg;
    round_t cnt_next;

    assign accept = start && !busy;
    assign busy   = (cnt_reg != '0);

    // cnt counts down while a key walks the chain; it reaches zero as the key enters the last cell
    always_comb
    begin
        if (accept)
        begin
            cnt_next = round_t'(ROUND_COUNT - 1);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - round_t'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // PC-1 at the chain's entry; parity bits drop out here
    assign links[0].valid = accept;
    assign links[0].cd    = pc1(cipher_key);

    for (genvar r = 0; r < ROUND_COUNT; r++)
    begin : g_cell
        drkg_cell #(
            .ROT (int'(ROT_TAB[r]))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .link_in  (links[r]),
            .link_out (links[r+1])
        );
    end

    // pick the one valid cell: one-hot, so an AND-OR is enough
    cd_t    sel_cd;
    round_t sel_num;
    logic   sel_valid;

    always_comb
    begin
        sel_cd    = '0;
        sel_num   = '0;
        sel_valid = 1'b0;
        for (int r = 0; r < ROUND_COUNT; r++)
        begin
            if (links[r+1].valid)
            begin
                sel_cd    = sel_cd | links[r+1].cd;
                sel_num   = sel_num | round_t'(r);
                sel_valid = 1'b1;
            end
        end
    end

    logic    round_valid_reg;
    subkey_t subkey_reg;
    round_t  round_number_reg;
    logic    last_round_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_valid_reg <= 1'b0;
        end
        else
        begin
            round_valid_reg <= sel_valid;
        end
    end

    // output word; PC-2 is wiring only
    always_ff @(posedge clk)
    begin
        if (sel_valid)
        begin
            subkey_reg       <= pc2(sel_cd);
            round_number_reg <= sel_num;
            last_round_reg   <= links[ROUND_COUNT].valid;
        end
    end

    assign round_valid  = round_valid_reg;
    assign subkey       = subkey_reg;
    assign round_number = round_number_reg;
    assign last_round   = last_round_reg;

endmodule

// File: hw/rtl/drkg_checker.sv
module drkg_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      round_valid,
    input drkg_pkg::round_t          round_number,
    input logic                      last_round
);
    import drkg_pkg::*;

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted key");

    a_first_round: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 (round_valid && round_number == '0))
        else $error("round 0 not emitted two cycles after start");

    a_round_seq: assert property (@(posedge clk) disable iff (!rst_n)
        round_valid && !last_round |=>
            round_valid && round_number == $past(round_number) + round_t'(1))
        else $error("round keys not consecutive");

    a_last_is_15: assert property (@(posedge clk) disable iff (!rst_n)
        round_valid && last_round |-> round_number == round_t'(ROUND_COUNT - 1))
        else $error("last flag on wrong round");

    a_busy_released: assert property (@(posedge clk) disable iff (!rst_n)
        round_valid && round_number == round_t'(ROUND_COUNT - 2) |-> !busy)
        else $error("busy held too long");

endmodule

bind des_round_key_generator_unit drkg_checker u_drkg_checker (.*);

// File: verif/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import drkg_pkg::key_t;
    import drkg_pkg::subkey_t;
    import drkg_pkg::round_t;

    // Key bit picks for the schedule. Positions count from 1 at the MSB,
    // as the DES standard writes them.
    localparam int CD_PICK [56] = '{
        57, 49, 41, 33, 25, 17,  9,  1, 58, 50, 42, 34, 26, 18,
        10,  2, 59, 51, 43, 35, 27, 19, 11,  3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15,  7, 62, 54, 46, 38, 30, 22,
        14,  6, 61, 53, 45, 37, 29, 21, 13,  5, 28, 20, 12,  4
    };

    localparam int SUBKEY_PICK [48] = '{
        14, 17, 11, 24,  1,  5,  3, 28, 15,  6, 21, 10,
        23, 19, 12,  4, 26,  8, 16,  7, 27, 20, 13,  2,
        41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
    };

    localparam int ROUNDS = 16;

    // Sender idle percentage per random phase; zero gives back-to-back keys.
    localparam int PHASE_IDLE_PCT [4] = '{0, 49, 0, 22};
    localparam int KEYS_PER_PHASE     = 92;

    typedef struct packed {
        subkey_t subkey;
        round_t  round;
        logic    last;
    } round_word_t;

    typedef subkey_t subkey_set_t [ROUNDS];

    // Directed rows: when pinned is set, every round key of that key is
    // known by inspection and is checked against pinned_subkey directly.
    typedef struct packed {
        key_t    key;
        logic    pinned;
        subkey_t pinned_subkey;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 14;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{64'h0000_0000_0000_0000, 1'b1, 48'h0000_0000_0000},  // all zero
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFF},  // all ones
        '{64'h0101_0101_0101_0101, 1'b1, 48'h0000_0000_0000},  // parity bits only
        '{64'hFEFE_FEFE_FEFE_FEFE, 1'b1, 48'hFFFF_FFFF_FFFF},  // all but parity
        '{64'h1334_5779_9BBC_DFF1, 1'b0, 48'h0},               // textbook key
        '{64'h1F1F_1F1F_0E0E_0E0E, 1'b0, 48'h0},               // weak key
        '{64'hE0E0_E0E0_F1F1_F1F1, 1'b0, 48'h0},               // weak key
        '{64'h01FE_01FE_01FE_01FE, 1'b0, 48'h0},               // semi-weak pair
        '{64'hFE01_FE01_FE01_FE01, 1'b0, 48'h0},
        '{64'h8000_0000_0000_0000, 1'b0, 48'h0},               // MSB only
        '{64'h0000_0000_0000_0002, 1'b0, 48'h0},               // lowest non-parity key bit
        '{64'h5555_5555_5555_5555, 1'b0, 48'h0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 48'h0},
        '{64'h0123_4567_89AB_CDEF, 1'b0, 48'h0}
    };

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    key_t    cipher_key;
    logic    round_valid;
    subkey_t subkey;
    round_t  round_number;
    logic    last_round;

    round_word_t expected_words [$];
    int          mismatch_count;

    des_round_key_generator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cipher_key   (cipher_key),
        .round_valid  (round_valid),
        .subkey       (subkey),
        .round_number (round_number),
        .last_round   (last_round)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Full key schedule: PC-1 into C:D, per-round rotate, PC-2 out.
    function automatic subkey_set_t derive_round_keys(input key_t key);
        logic [55:0]        cd;
        logic [27:0]        c_half;
        logic [27:0]        d_half;
        logic [55:0]        joined;
        subkey_t            sk;
        subkey_set_t        keys;
        int                 shift;
        cd = '0;
        for (int k = 0; k < 56; k++)
        begin
            cd = {cd[54:0], key[64 - CD_PICK[k]]};
        end
        c_half = cd[55:28];
        d_half = cd[27:0];
        for (int r = 0; r < ROUNDS; r++)
        begin
            // single-bit rotate in rounds 1, 2, 9 and 16, double elsewhere
            shift = (r == 0 || r == 1 || r == 8 || r == 15) ? 1 : 2;
            repeat (shift)
            begin
                c_half = {c_half[26:0], c_half[27]};
                d_half = {d_half[26:0], d_half[27]};
            end
            joined = {c_half, d_half};
            sk = '0;
            for (int k = 0; k < 48; k++)
            begin
                sk = {sk[46:0], joined[56 - SUBKEY_PICK[k]]};
            end
            keys[r] = sk;
        end
        return keys;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Present one key, holding start until the block takes it, then queue
    // its sixteen expected words. While idle the key bus carries junk that
    // the block must ignore.
    task automatic send_key(input key_t key, input int idle_pct, input logic pinned,
                            input subkey_t pinned_subkey);
        subkey_set_t keys;
        round_word_t word;
        while ($urandom_range(99) < idle_pct)
        begin
            start      <= 1'b0;
            cipher_key <= {$urandom, $urandom};
            @(posedge clk);
        end
        start      <= 1'b1;
        cipher_key <= key;
        do
            @(posedge clk);
        while (busy);
        keys = derive_round_keys(key);
        for (int r = 0; r < ROUNDS; r++)
        begin
            word.subkey = pinned ? pinned_subkey : keys[r];
            word.round  = round_t'(r);
            word.last   = (r == ROUNDS - 1);
            expected_words.push_back(word);
        end
    endtask

    // Output side: every strobed word is compared against the oldest pending one.
    always @(posedge clk)
    begin
        round_word_t want;
        if (rst_n && round_valid)
        begin
            if (expected_words.size() == 0)
            begin
                flag_mismatch("unexpected round key", 64'(subkey), 64'h0);
            end
            else
            begin
                want = expected_words.pop_front();
                if (subkey !== want.subkey)
                    flag_mismatch("subkey", 64'(subkey), 64'(want.subkey));
                if (round_number !== want.round)
                    flag_mismatch("round_number", 64'(round_number), 64'(want.round));
                if (last_round !== want.last)
                    flag_mismatch("last_round", 64'(last_round), 64'(want.last));
            end
        end
    end

    initial
    begin
        key_t key;
        int   pick;
        mismatch_count = 0;
        rst_n          = 1'b0;
        start          = 1'b0;
        cipher_key     = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed keys, back to back
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_key(DIRECTED[i].key, 0, DIRECTED[i].pinned, DIRECTED[i].pinned_subkey);
        end

        // random keys, mostly dense, some sparse and weak-key shaped
        for (int p = 0; p < 4; p++)
        begin
            for (int i = 0; i < KEYS_PER_PHASE; i++)
            begin
                pick = $urandom_range(9);
                case (pick)
                    0:       key = 64'h1 << $urandom_range(63);
                    1:       key = ~(64'h1 << $urandom_range(63));
                    2:       key = {{4{8'($urandom)}}, {4{8'($urandom)}}};
                    default: key = {$urandom, $urandom};
                endcase
                send_key(key, PHASE_IDLE_PCT[p], 1'b0, '0);
            end
        end
        start <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        // drain: leave margin after the last word has shown
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog: a clean run finishes well under a third of this
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
